/* design/lpkt_pkg.sv */
// Shared widths, outcome codes and controller/datapath interface types for the key table.
package lpkt_pkg;

    localparam int KEY_W       = 32;
    localparam int SIZE_W      = 9;
    localparam int SLOT_W      = 8;
    localparam int COUNT_W     = 9;
    localparam int OUTCOME_W   = 2;
    localparam int DEPTH_DEF    = 256;
    localparam int KEY_BITS_DEF = 32;

    localparam logic [OUTCOME_W-1:0] OUT_FOUND    = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_RESERVED = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_ABSENT   = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_FULL     = 2'd3;

    typedef struct packed {
        logic clear;   // write one zero entry of the clearing pass
        logic accept;  // latch the request, start the remainder unit
        logic home;    // load the probe index with the home slot
        logic rd;      // read the slot at the probe index
        logic check;   // evaluate the slot just read
        logic emit;    // load the result register
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic mod_done;
        logic stop;
        logic out_free;
    } t_stat;

endpackage

/* design/lpkt_mod.sv */
// Iterative remainder unit: key modulo table size, four quotient bits per cycle.
module lpkt_mod #(
    parameter int KW  = 32,
    parameter int SZW = 9
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [KW-1:0]  i_num,
    input  logic [SZW-1:0] i_den,
    output logic           o_done,
    output logic [SZW-1:0] o_rem
);

    localparam int NSTEP = (KW + 3) / 4;
    localparam int PW    = NSTEP * 4;
    localparam int CW    = $clog2(NSTEP);

    logic [PW-1:0]  r_num;
    logic [SZW-1:0] r_rem;
    logic [SZW-1:0] n_rem;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [SZW:0]   w_t;

    // Four restoring steps; the partial remainder stays below the divisor.
    always_comb begin
        n_rem = r_rem;
        w_t   = '0;
        for (int s = 0; s < 4; s++) begin
            w_t = {n_rem, r_num[PW-1-s]};
            if (w_t >= {1'b0, i_den}) begin
                w_t = w_t - {1'b0, i_den};
            end
            n_rem = w_t[SZW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NSTEP - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= PW'(i_num);
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 4;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* design/lpkt_ctrl.sv */
// Sequencer for clearing, home slot computation, probe walk and result hand-off.
module lpkt_ctrl import lpkt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MOD;
                end
            end
            S_MOD: begin
                if (i_stat.mod_done) begin
                    o_cmd.home = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_stat.stop ? S_EMIT : S_READ;
            end
            S_EMIT: begin
                // hold the finished result until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* design/lpkt_dp.sv */
// Datapath: slot memory, size and count registers, probe index, result register.
module lpkt_dp import lpkt_pkg::*; #(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_cfg_we,
    input  logic [SIZE_W-1:0]    i_cfg_wdata,
    input  logic                 i_req_type,
    input  logic [KEY_W-1:0]     i_key,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [OUTCOME_W-1:0] o_outcome,
    output logic [SLOT_W-1:0]    o_slot_index,
    output logic [COUNT_W-1:0]   o_entry_count
);

    localparam int KW  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int IW  = $clog2(DEPTH);
    localparam int SZW = $clog2(DEPTH + 1);

    // each entry holds {used, key}
    logic [KW:0]            mem [DEPTH];

    logic [SZW-1:0]         r_size;
    logic [SZW-1:0]         w_cfg_size;
    logic [KW-1:0]          r_key;
    logic                   r_reserve;
    logic [IW-1:0]          r_idx;
    logic [IW-1:0]          r_home;
    logic [IW-1:0]          r_clr;
    logic [KW:0]            r_rd;
    logic [COUNT_W-1:0]     r_count;
    logic [OUTCOME_W-1:0]   r_res_outcome;
    logic [IW-1:0]          r_res_slot;
    logic                   r_out_valid;
    logic [OUTCOME_W-1:0]   r_outcome;
    logic [SLOT_W-1:0]      r_slot;
    logic [COUNT_W-1:0]     r_entry;

    logic                   w_mod_done;
    logic [SZW-1:0]         w_rem;
    logic                   w_used;
    logic                   w_match;
    logic [IW-1:0]          w_next;
    logic                   w_wrap;
    logic                   w_stop;
    logic                   w_we;
    logic [31:0]            w_slot_ext;

    lpkt_mod #(
        .KW  (KW),
        .SZW (SZW)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.accept),
        .i_num   (i_key[KW-1:0]),
        .i_den   (r_size),
        .o_done  (w_mod_done),
        .o_rem   (w_rem)
    );

    // zero acts as one, anything past the memory saturates to its depth
    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_cfg_size = SZW'(1);
        end else if (32'(i_cfg_wdata) > 32'(DEPTH)) begin
            w_cfg_size = SZW'(DEPTH);
        end else begin
            w_cfg_size = SZW'(i_cfg_wdata);
        end
    end

    assign w_used  = r_rd[KW];
    assign w_match = w_used && (r_rd[KW-1:0] == r_key);
    assign w_next  = ((SZW'(r_idx) + SZW'(1)) == r_size) ? '0 : IW'(r_idx + 1'b1);
    assign w_wrap  = (w_next == r_home);
    assign w_stop  = !w_used || w_match || w_wrap;
    assign w_we    = i_cmd.check && !w_used && r_reserve;

    assign o_stat.clr_last = (r_clr == IW'(DEPTH - 1));
    assign o_stat.mod_done = w_mod_done;
    assign o_stat.stop     = w_stop;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mem[r_clr] <= '0;
        end else if (w_we) begin
            mem[r_idx] <= {1'b1, r_key};
        end
        if (i_cmd.rd) begin
            r_rd <= mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= SZW'(DEPTH);
            r_count     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= w_cfg_size;
            end
            if (i_cmd.clear) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_we && (r_count != '1)) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key     <= i_key[KW-1:0];
            r_reserve <= i_req_type;
        end
        if (i_cmd.home) begin
            r_idx  <= IW'(w_rem);
            r_home <= IW'(w_rem);
        end else if (i_cmd.check && !w_stop) begin
            r_idx <= w_next;
        end
        if (i_cmd.check && w_stop) begin
            if (!w_used) begin
                r_res_outcome <= r_reserve ? OUT_RESERVED : OUT_ABSENT;
                r_res_slot    <= r_reserve ? r_idx : '0;
            end else if (w_match) begin
                r_res_outcome <= OUT_FOUND;
                r_res_slot    <= r_idx;
            end else begin
                r_res_outcome <= OUT_FULL;
                r_res_slot    <= '0;
            end
        end
        if (i_cmd.emit) begin
            r_outcome <= r_res_outcome;
            r_slot    <= w_slot_ext[SLOT_W-1:0];
            r_entry   <= r_count;
        end
    end

    assign w_slot_ext = 32'(r_res_slot);

    assign o_out_valid   = r_out_valid;
    assign o_outcome     = r_outcome;
    assign o_slot_index  = r_slot;
    assign o_entry_count = r_entry;

endmodule

/* design/linear_probe_key_table.sv */
// Open-addressed key table with linear probing.
// Requests arrive on the input valid/ready channel: req_type 0 looks a key up,
// req_type 1 finds the key or reserves the first empty slot on its probe walk.
// Each request gives exactly one result on the output valid/ready channel:
// outcome, slot_index and the entry count after the request.
// The table size register is written through i_cfg_we/i_cfg_wdata; the user
// must write it only while idle; the block does not enforce this. Zero acts as
// one, values above DEPTH saturate to DEPTH. A request is accepted, then the
// remainder unit computes its home slot, then each probed slot takes a memory
// read and then a compare, then the result register is loaded. One request is
// in flight at a time; the next is taken once the result is in the output
// register, even while that result still waits to be taken. If the receiver
// stalls, the finished request holds until the register frees. After reset the
// slot memory is cleared one entry per cycle, all DEPTH entries, with o_in_ready
// low; the table size returns to DEPTH and the count to zero.
module linear_probe_key_table import lpkt_pkg::*; #(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [SIZE_W-1:0]    i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_req_type,
    input  logic [KEY_W-1:0]     i_key,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [OUTCOME_W-1:0] o_outcome,
    output logic [SLOT_W-1:0]    o_slot_index,
    output logic [COUNT_W-1:0]   o_entry_count
);

    t_cmd  w_cmd;
    t_stat w_stat;

    lpkt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lpkt_dp #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_type    (i_req_type),
        .i_key         (i_key),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_outcome     (o_outcome),
        .o_slot_index  (o_slot_index),
        .o_entry_count (o_entry_count)
    );

`ifndef SYNTHESIS
    // one request at a time: a transfer in drops ready on the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a request is in flight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_entry_count) <= 32'(DEPTH)))
        else $error("entry count above table depth");

    a_absent_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_outcome == OUT_ABSENT || o_outcome == OUT_FULL)
        |-> (o_slot_index == '0))
        else $error("nonzero slot on absent or full result");

    a_count_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_entry_count))
        else $error("result count changed while stalled");
`endif

endmodule

/* tb/sv/key_table_checker.sv */
// Checker for the key table: predicts every reply from the transfers it sees and compares.
module key_table_checker import lpkt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [SIZE_W-1:0]    i_cfg_wdata,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_req_type,
    input  logic [KEY_W-1:0]     i_key,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [OUTCOME_W-1:0] i_outcome,
    input  logic [SLOT_W-1:0]    i_slot_index,
    input  logic [COUNT_W-1:0]   i_entry_count,
    output int                   o_fail_count,
    output int                   o_awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [SLOT_W-1:0]    slot;
        logic [COUNT_W-1:0]   count;
    } t_reply;

    logic [DEPTH_DEF-1:0] shadow_used;
    logic [KEY_W-1:0]     shadow_key [DEPTH_DEF];
    logic [COUNT_W-1:0]   shadow_count;
    logic [SIZE_W-1:0]    shadow_size;
    t_reply               awaited_replies [$];
    int                   fails = 0;

    // Walk the shadow table from the home slot; claim the first free slot on a reserve.
    function automatic t_reply walk_table(input logic reserve, input logic [KEY_W-1:0] k);
        int unsigned span;
        int unsigned idx;
        int unsigned n;
        logic        done;
        t_reply      r;
        if (shadow_size == 0)
            span = 1;
        else if (shadow_size > DEPTH_DEF)
            span = DEPTH_DEF;
        else
            span = shadow_size;
        idx = k % span;
        done = 1'b0;
        r.outcome = OUT_FULL;
        r.slot = '0;
        for (n = 0; n < span && !done; n++) begin
            if (!shadow_used[idx]) begin
                if (reserve) begin
                    shadow_used[idx] = 1'b1;
                    shadow_key[idx] = k;
                    if (shadow_count != '1)
                        shadow_count++;
                    r.outcome = OUT_RESERVED;
                    r.slot = SLOT_W'(idx);
                end else begin
                    r.outcome = OUT_ABSENT;
                end
                done = 1'b1;
            end else if (shadow_key[idx] == k) begin
                r.outcome = OUT_FOUND;
                r.slot = SLOT_W'(idx);
                done = 1'b1;
            end else begin
                idx = (idx + 1) % span;
            end
        end
        r.count = shadow_count;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            shadow_used = '0;
            shadow_count = '0;
            shadow_size = SIZE_W'(DEPTH_DEF);
            awaited_replies.delete();
        end else begin
            // Retire the reply first: it always belongs to an earlier request.
            if (i_out_valid && i_out_ready) begin
                if (awaited_replies.size() == 0) begin
                    $error("unexpected reply: outcome %0d slot_index %0d entry_count %0d",
                           i_outcome, i_slot_index, i_entry_count);
                    fails++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (i_outcome !== want.outcome) begin
                        $error("outcome: expected %0d, actual %0d", want.outcome, i_outcome);
                        fails++;
                    end
                    if (i_slot_index !== want.slot) begin
                        $error("slot_index: expected %0d, actual %0d", want.slot, i_slot_index);
                        fails++;
                    end
                    if (i_entry_count !== want.count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.count, i_entry_count);
                        fails++;
                    end
                end
            end
            if (i_cfg_we)
                shadow_size = i_cfg_wdata;
            if (i_in_valid && i_in_ready)
                awaited_replies.push_back(walk_table(i_req_type, i_key));
        end
        o_fail_count <= fails;
        o_awaited <= awaited_replies.size();
    end

endmodule

/* tb/sv/linear_probe_key_table_tb.sv */
// Testbench top for the key table: clock, reset, request and reply traffic, verdict.
module linear_probe_key_table_tb import lpkt_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REQ_LOOKUP  = 1'b0;
    localparam logic REQ_RESERVE = 1'b1;
    localparam int   CYCLE_LIMIT = 2_000_000;
    localparam int   DRAIN_WAIT  = 40;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [SIZE_W-1:0]    cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 req_type = 1'b0;
    logic [KEY_W-1:0]     key = '0;
    logic                 out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [OUTCOME_W-1:0] o_outcome;
    logic [SLOT_W-1:0]    o_slot_index;
    logic [COUNT_W-1:0]   o_entry_count;
    int                   fail_count;
    int                   awaited;

    int unsigned          table_span = DEPTH_DEF;
    int                   in_calm = 0;
    logic [KEY_W-1:0]     recent_keys [$];
    longint unsigned      cycles = 0;

    linear_probe_key_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (req_type),
        .i_key         (key),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_outcome     (o_outcome),
        .o_slot_index  (o_slot_index),
        .o_entry_count (o_entry_count)
    );

    key_table_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .i_in_ready    (o_in_ready),
        .i_req_type    (req_type),
        .i_key         (key),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .i_outcome     (o_outcome),
        .i_slot_index  (o_slot_index),
        .i_entry_count (o_entry_count),
        .o_fail_count  (fail_count),
        .o_awaited     (awaited)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[linear_probe_key_table] ERROR");
            $finish;
        end
    end

    // Gap ahead of a request: mostly none, some short, a few long, with calm stretches.
    function automatic int pick_gap();
        int unsigned roll;
        if (in_calm > 0) begin
            in_calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            in_calm = $urandom_range(30, 100);
            return 0;
        end
        if (roll < 70)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Reuse a recent key, aim a key at the low home slots, or take any key.
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned     roll;
        longint unsigned q;
        roll = $urandom_range(0, 99);
        if (roll < 40 && recent_keys.size() > 0)
            return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        if (roll < 65) begin
            q = $urandom_range(0, 32'hFFFF_FFFF / table_span);
            return KEY_W'(q * table_span +
                          $urandom_range(0, (table_span > 4) ? 3 : table_span - 1));
        end
        return $urandom();
    endfunction

    // Present one request and hold it until the transfer; valid stays up for a back-to-back one.
    task automatic send_request(input logic op, input logic [KEY_W-1:0] k);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        req_type <= op;
        key <= k;
        do @(posedge i_clk); while (!o_in_ready);
        recent_keys.push_back(k);
        if (recent_keys.size() > 96)
            recent_keys.delete(0);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (awaited != 0);
    endtask

    task automatic set_table_size(input logic [SIZE_W-1:0] size);
        wait_idle();
        repeat (4) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= size;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (size == 0)
            table_span = 1;
        else if (size > DEPTH_DEF)
            table_span = DEPTH_DEF;
        else
            table_span = size;
    endtask

    // Reply side: random stalls, calm stretches, and two long hold-offs to back up the input.
    initial begin : reply_side
        int stall;
        int calm;
        int taken;
        int unsigned roll;
        stall = 0;
        calm = 0;
        taken = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && out_ready) begin
                taken++;
                if (taken % 300 == 150)
                    stall = 400;
            end
            if (stall > 0) begin
                stall--;
                out_ready <= 1'b0;
            end else if (calm > 0) begin
                calm--;
                out_ready <= 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    calm = $urandom_range(40, 150);
                    out_ready <= 1'b1;
                end else if (roll < 65) begin
                    out_ready <= 1'b1;
                end else begin
                    if (roll < 90)
                        stall = $urandom_range(0, 2);
                    else if (roll < 98)
                        stall = $urandom_range(3, 12);
                    else
                        stall = $urandom_range(20, 60);
                    out_ready <= 1'b0;
                end
            end
        end
    end

    initial begin : request_side
        logic [SIZE_W-1:0] phase_sizes [12];
        logic              op;
        phase_sizes = '{9'd5, 9'd2, 9'd17, 9'd64, 9'd0, 9'd130,
                        9'd256, 9'd511, 9'd9, 9'd255, 9'd1, 9'd256};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, collisions, wrap past the last slot, home slot 255.
        send_request(REQ_LOOKUP, 32'h0000_0000);
        send_request(REQ_RESERVE, 32'h0000_0000);
        send_request(REQ_RESERVE, 32'h0000_0000);
        send_request(REQ_RESERVE, 32'h0000_0100);
        send_request(REQ_LOOKUP, 32'h0000_0200);
        send_request(REQ_RESERVE, 32'hFFFF_FFFF);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF);
        send_request(REQ_RESERVE, 32'h0000_01FF);

        // Size zero acts as one: the walk wraps at once.
        set_table_size(9'd0);
        send_request(REQ_LOOKUP, 32'h0000_0005);
        send_request(REQ_RESERVE, 32'h0000_0000);
        send_request(REQ_RESERVE, 32'h1234_5678);

        // Oversize saturates to the full depth.
        set_table_size(9'd511);
        send_request(REQ_LOOKUP, 32'h0000_01FF);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF);

        // Shrunk table: all visible slots taken, upper slot still counted.
        set_table_size(9'd3);
        send_request(REQ_RESERVE, 32'h0000_0001);
        send_request(REQ_LOOKUP, 32'h7FFF_FFFF);
        send_request(REQ_LOOKUP, 32'h0000_0100);

        set_table_size(9'd1);
        send_request(REQ_RESERVE, 32'hAAAA_AAAA);
        send_request(REQ_LOOKUP, 32'h0000_0000);

        set_table_size(9'd256);
        send_request(REQ_LOOKUP, 32'h5555_5555);
        send_request(REQ_RESERVE, 32'h5555_5555);

        foreach (phase_sizes[p]) begin
            set_table_size(phase_sizes[p]);
            repeat (50) begin
                op = ($urandom_range(0, 99) < 55) ? REQ_RESERVE : REQ_LOOKUP;
                send_request(op, pick_key());
            end
        end

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && awaited == 0)
            $display("[linear_probe_key_table] OK");
        else
            $display("[linear_probe_key_table] ERROR");
        $finish;
    end

endmodule
